// ----- sv/base85_byte_encoder_unit_assert.svh -----
// Assertion macros for the base85 byte encoder checker.
// Included by the checker file only; depends on nothing else.
`ifndef BASE85_BYTE_ENCODER_UNIT_ASSERT_SVH
`define BASE85_BYTE_ENCODER_UNIT_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define BBE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define BBE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent, reset included.
`define BBE_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
   lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/bbe_pkg.sv -----
// Shared types, constants and the alphabet function of the base85 encoder.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package bbe_pkg;

   // Depth of the group queue between the front and the converter.
   localparam int GROUP_DEPTH = 2;
   localparam int GROUP_PTR_W = $clog2(GROUP_DEPTH);
   localparam int GROUP_FILL_W = $clog2(GROUP_DEPTH + 1);

   // Depth of the character queue at the result side.
   localparam int CHAR_DEPTH = 2;
   localparam int CHAR_PTR_W = $clog2(CHAR_DEPTH);
   localparam int CHAR_FILL_W = $clog2(CHAR_DEPTH + 1);

   // Division by 85 as a multiply by a rounded-up reciprocal: exact for 32-bit values.
   localparam logic [31:0] DIV_MAGIC = 32'd3233857729;
   localparam int DIV_SHIFT = 38;
   localparam logic [31:0] BASE = 32'd85;

   // Alphabet codes held in the configuration register.
   localparam logic ALPHA_ASCII85 = 1'b0;
   localparam logic ALPHA_Z85 = 1'b1;

   // One padded group: count is the number of bytes held minus one.
   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  count;
      logic        last;
   } group_type;

   // Five digits of a group, most significant digit at index 0.
   typedef struct packed {
      logic [4:0][6:0] digits;
      logic [1:0]      count;
      logic            last;
   } digit_set_type;

   // One result character.
   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } char_type;

   typedef enum logic [1:0] {
      CONV_IDLE,
      CONV_DIV,
      CONV_DONE
   } conv_state_type;

   // Maps one base-85 digit to its printable character.
   function automatic logic [6:0] map_digit(input logic sel, input logic [6:0] d);
      logic [6:0] c;
      if (sel == ALPHA_ASCII85) begin
         c = 7'(d + 7'd33);
      end else if (d < 7'd10) begin
         c = 7'(d + 7'd48);
      end else if (d < 7'd36) begin
         c = 7'(d + 7'd87);
      end else if (d < 7'd62) begin
         c = 7'(d + 7'd29);
      end else begin
         case (d)
            7'd62: c = 7'd46;
            7'd63: c = 7'd45;
            7'd64: c = 7'd58;
            7'd65: c = 7'd43;
            7'd66: c = 7'd61;
            7'd67: c = 7'd94;
            7'd68: c = 7'd33;
            7'd69: c = 7'd47;
            7'd70: c = 7'd42;
            7'd71: c = 7'd63;
            7'd72: c = 7'd38;
            7'd73: c = 7'd60;
            7'd74: c = 7'd62;
            7'd75: c = 7'd40;
            7'd76: c = 7'd41;
            7'd77: c = 7'd91;
            7'd78: c = 7'd93;
            7'd79: c = 7'd123;
            7'd80: c = 7'd125;
            7'd81: c = 7'd64;
            7'd82: c = 7'd37;
            7'd83: c = 7'd36;
            default: c = 7'd35;
         endcase
      end
      return c;
   endfunction

endpackage

// ----- sv/bbe_group_fifo.sv -----
// Short queue of padded groups between the front and the converter.
// Depends on bbe_pkg.
`timescale 1ns / 1ps

module bbe_group_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bbe_pkg::group_type push_data,
   output logic               full,
   input  logic               pop,
   output logic               valid,
   output bbe_pkg::group_type pop_data
);
   import bbe_pkg::*;

   group_type                slot_ff [GROUP_DEPTH];
   logic [GROUP_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [GROUP_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [GROUP_FILL_W-1:0]  fill_ff, fill_in;
   logic                     do_push, do_pop;

   assign full     = (fill_ff == GROUP_FILL_W'(GROUP_DEPTH));
   assign valid    = (fill_ff != '0);
   assign pop_data = slot_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // Pointer and fill bookkeeping.
   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == GROUP_PTR_W'(GROUP_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == GROUP_PTR_W'(GROUP_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         fill_ff <= fill_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

endmodule

// ----- sv/bbe_front.sv -----
// Front end: accepts bytes, packs them into a group and hands full or final groups on.
// Depends on bbe_pkg.
`timescale 1ns / 1ps

module bbe_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic [7:0]         req_data_byte,
   input  logic               req_final_byte,
   output logic               group_push,
   output bbe_pkg::group_type group_data,
   input  logic               group_full
);
   import bbe_pkg::*;

   logic [23:0] word_ff, word_in;
   logic [1:0]  count_ff, count_in;
   logic        accept, flush;

   assign req_full = group_full;
   assign accept   = req_push && !group_full;
   assign flush    = req_final_byte || (count_ff == 2'd3);

   // Pad the group with zero bytes on the right.
   always_comb begin
      case (count_ff)
         2'd0:    group_data.value = {req_data_byte, 24'h0};
         2'd1:    group_data.value = {word_ff[7:0], req_data_byte, 16'h0};
         2'd2:    group_data.value = {word_ff[15:0], req_data_byte, 8'h0};
         default: group_data.value = {word_ff, req_data_byte};
      endcase
      group_data.count = count_ff;
      group_data.last  = req_final_byte;
   end

   assign group_push = accept && flush;

   // Gather bytes until a flush clears the group.
   always_comb begin
      word_in  = word_ff;
      count_in = count_ff;
      if (accept) begin
         if (flush) begin
            word_in  = '0;
            count_in = '0;
         end else begin
            word_in  = {word_ff[15:0], req_data_byte};
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         count_ff <= '0;
      end else begin
         word_ff  <= word_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- sv/bbe_convert.sv -----
// Converter: turns a padded group into five base-85 digits, one division per cycle.
// Depends on bbe_pkg.
`timescale 1ns / 1ps

module bbe_convert (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   group_valid,
   input  bbe_pkg::group_type     group_data,
   output logic                   group_pop,
   output logic                   set_valid,
   output bbe_pkg::digit_set_type set_data,
   input  logic                   set_ready
);
   import bbe_pkg::*;

   conv_state_type  state_ff, state_in;
   logic [31:0]     dividend_ff, dividend_in;
   logic [25:0]     quot_ff, quot_in;
   logic [1:0]      step_ff, step_in;
   logic [4:0][6:0] digits_ff, digits_in;
   logic [1:0]      count_ff, count_in;
   logic            last_ff, last_in;
   logic            load;
   logic [31:0]     mul_in;
   logic [63:0]     product;
   logic [31:0]     remain;

   // A new group starts when the converter is free or its result leaves now.
   assign load = group_valid &&
                 ((state_ff == CONV_IDLE) || ((state_ff == CONV_DONE) && set_ready));

   // Next state.
   always_comb begin
      case (state_ff)
         CONV_IDLE: state_in = group_valid ? CONV_DIV : CONV_IDLE;
         CONV_DIV:  state_in = (step_ff == 2'd3) ? CONV_DONE : CONV_DIV;
         CONV_DONE: begin
            if (set_ready) begin
               state_in = group_valid ? CONV_DIV : CONV_IDLE;
            end else begin
               state_in = CONV_DONE;
            end
         end
         default:   state_in = CONV_IDLE;
      endcase
   end

   // Handshake outputs.
   always_comb begin
      group_pop = load;
      set_valid = (state_ff == CONV_DONE);
   end

   assign set_data.digits = digits_ff;
   assign set_data.count  = count_ff;
   assign set_data.last   = last_ff;

   // Quotient by 85 of either the new group or the last quotient.
   assign mul_in  = load ? group_data.value : {6'b0, quot_ff};
   assign product = 64'(mul_in) * 64'(DIV_MAGIC);
   assign remain  = dividend_ff - 32'({6'b0, quot_ff} * BASE);

   // Digits come out least significant first and shift in from the bottom.
   always_comb begin
      dividend_in = dividend_ff;
      quot_in     = quot_ff;
      step_in     = step_ff;
      digits_in   = digits_ff;
      count_in    = count_ff;
      last_in     = last_ff;
      if (load) begin
         dividend_in = group_data.value;
         quot_in     = product[63:DIV_SHIFT];
         step_in     = '0;
         count_in    = group_data.count;
         last_in     = group_data.last;
      end else if (state_ff == CONV_DIV) begin
         dividend_in = {6'b0, quot_ff};
         quot_in     = product[63:DIV_SHIFT];
         step_in     = step_ff + 1'b1;
         if (step_ff == 2'd3) begin
            digits_in = {digits_ff[2:0], remain[6:0], quot_ff[6:0]};
         end else begin
            digits_in = {digits_ff[3:0], remain[6:0]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CONV_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      dividend_ff <= dividend_in;
      quot_ff     <= quot_in;
      digits_ff   <= digits_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
   end

endmodule

// ----- sv/bbe_emit.sv -----
// Emitter: maps digits through the selected alphabet and queues the characters.
// Holds the alphabet register. Depends on bbe_pkg.
`timescale 1ns / 1ps

module bbe_emit (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   input  logic                   csr_data,
   input  logic                   set_valid,
   input  bbe_pkg::digit_set_type set_data,
   output logic                   set_ready,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [6:0]             rsp_code_char,
   output logic                   rsp_final_char
);
   import bbe_pkg::*;

   logic                    alpha_ff, alpha_in;
   logic                    busy_ff, busy_in;
   digit_set_type           set_ff, set_in;
   logic [2:0]              idx_ff, idx_in;
   char_type                slot_ff [CHAR_DEPTH];
   logic [CHAR_PTR_W-1:0]   wptr_ff, wptr_in;
   logic [CHAR_PTR_W-1:0]   rptr_ff, rptr_in;
   logic [CHAR_FILL_W-1:0]  fill_ff, fill_in;
   logic                    room, do_push, do_pop, end_of_set, take;
   char_type                next_char;

   // Alphabet register; the port is always ready.
   assign alpha_in = csr_valid ? csr_data : alpha_ff;

   assign room       = (fill_ff != CHAR_FILL_W'(CHAR_DEPTH));
   assign do_push    = busy_ff && room;
   assign end_of_set = (idx_ff == {1'b0, set_ff.count} + 3'd1);
   assign set_ready  = !busy_ff || (do_push && end_of_set);
   assign take       = set_valid && set_ready;

   assign next_char.code = map_digit(alpha_ff, set_ff.digits[idx_ff]);
   assign next_char.last = set_ff.last && end_of_set;

   // Walk the digits of the held set, one character per transfer into the queue.
   always_comb begin
      busy_in = busy_ff;
      set_in  = set_ff;
      idx_in  = idx_ff;
      if (do_push) begin
         idx_in = idx_ff + 3'd1;
         if (end_of_set) begin
            busy_in = 1'b0;
         end
      end
      if (take) begin
         busy_in = 1'b1;
         set_in  = set_data;
         idx_in  = '0;
      end
   end

   // Result queue bookkeeping.
   assign rsp_empty      = (fill_ff == '0);
   assign do_pop         = rsp_pop && !rsp_empty;
   assign rsp_code_char  = slot_ff[rptr_ff].code;
   assign rsp_final_char = slot_ff[rptr_ff].last;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      fill_in = fill_ff;
      if (do_push) begin
         wptr_in = (wptr_ff == CHAR_PTR_W'(CHAR_DEPTH - 1)) ? '0 : wptr_ff + 1'b1;
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == CHAR_PTR_W'(CHAR_DEPTH - 1)) ? '0 : rptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff <= ALPHA_Z85;
         busy_ff  <= 1'b0;
         idx_ff   <= '0;
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         fill_ff  <= '0;
      end else begin
         alpha_ff <= alpha_in;
         busy_ff  <= busy_in;
         idx_ff   <= idx_in;
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         fill_ff  <= fill_in;
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      set_ff <= set_in;
      if (do_push) begin
         slot_ff[wptr_ff] <= next_char;
      end
   end

endmodule

// ----- sv/base85_byte_encoder_unit.sv -----
// Top level of the streaming base85 byte encoder.
// Instantiates bbe_front, bbe_group_fifo, bbe_convert and bbe_emit; uses bbe_pkg.
`timescale 1ns / 1ps

// Takes one byte per transfer on the req_ side and returns base85 characters on
// the rsp_ side, five for each group of four bytes and k+1 for a final group of
// k bytes, the last one flagged by rsp_final_char. A byte is taken whenever the
// two-entry group queue has room; a group passes the converter as a load and four
// divisions by 85 (each one 32 by 32 multiply by the reciprocal), and the emitter
// sends one character per cycle while the result queue has room, so a stream is
// limited by the five-character output per group. csr_data picks the alphabet
// (1: Z85, 0: Ascii85, reset Z85) and is to be written only while idle; the block
// itself does not enforce this.

module base85_byte_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_code_char,
   output logic       rsp_final_char,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_data
);
   import bbe_pkg::*;

   group_type     front_group, queue_group;
   logic          front_push, queue_full, queue_valid, queue_pop;
   digit_set_type digit_set;
   logic          set_valid, set_ready;

   assign csr_ready = 1'b1;

   bbe_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_data_byte  (req_data_byte),
      .req_final_byte (req_final_byte),
      .group_push     (front_push),
      .group_data     (front_group),
      .group_full     (queue_full)
   );

   bbe_group_fifo u_group_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (front_push),
      .push_data (front_group),
      .full      (queue_full),
      .pop       (queue_pop),
      .valid     (queue_valid),
      .pop_data  (queue_group)
   );

   bbe_convert u_convert (
      .clock       (clock),
      .reset       (reset),
      .group_valid (queue_valid),
      .group_data  (queue_group),
      .group_pop   (queue_pop),
      .set_valid   (set_valid),
      .set_data    (digit_set),
      .set_ready   (set_ready)
   );

   bbe_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_data       (csr_data),
      .set_valid      (set_valid),
      .set_data       (digit_set),
      .set_ready      (set_ready),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_code_char  (rsp_code_char),
      .rsp_final_char (rsp_final_char)
   );

endmodule

// ----- sv/bbe_checker.sv -----
// Port-level checker for the base85 byte encoder and its bind to the top level.
// Depends on base85_byte_encoder_unit_assert.svh.
`timescale 1ns / 1ps
`include "base85_byte_encoder_unit_assert.svh"

module bbe_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_full,
   input logic       rsp_empty,
   input logic       rsp_pop,
   input logic [6:0] rsp_code_char,
   input logic       rsp_final_char,
   input logic       csr_ready
);

   // A waiting character that is not taken stays put.
   `BBE_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_code_char) && $stable(rsp_final_char), "result changed while stalled")

   // Every character shown is printable and within the alphabets.
   `BBE_ASSERT_NOW(a_char_range, clock, reset, !rsp_empty, (rsp_code_char >= 7'd33) && (rsp_code_char <= 7'd125), "character out of range")

   // Reset leaves both queues empty and the block able to take input.
   `BBE_ASSERT_ALWAYS_NEXT(a_reset_clear, clock, reset, rsp_empty && !req_full && csr_ready, "queues not cleared by reset")

endmodule

bind base85_byte_encoder_unit bbe_checker u_bbe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_code_char  (rsp_code_char),
   .rsp_final_char (rsp_final_char),
   .csr_ready      (csr_ready)
);
